@@ rtl/lmrs_pkg.sv @@
// ----------------------------------------------------------------------------
// lmrs_pkg
// Shared types and constants of the LED matrix row scanner: word layouts of
// the input and output channels and the per-step info passed down the pipe.
// ----------------------------------------------------------------------------
package lmrs_pkg;

  // Number of red shift-register lanes (planes)
  localparam int unsigned LANES = 4;
  localparam int unsigned BYTE_W = 8;

  // Input word kinds (carried on tuser)
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  // Input tdata layout: plane, row, column_byte, pixel_byte from bit 0 up
  localparam int unsigned IN_TDATA_W = 24;
  localparam int unsigned PLANE_W    = 2;
  localparam int unsigned ROW_FLD_W  = 4;
  localparam int unsigned COL_FLD_W  = 3;
  localparam int unsigned IN_PLANE_LSB = 0;
  localparam int unsigned IN_ROW_LSB   = IN_PLANE_LSB + PLANE_W;
  localparam int unsigned IN_COL_LSB   = IN_ROW_LSB + ROW_FLD_W;
  localparam int unsigned IN_PIX_LSB   = IN_COL_LSB + COL_FLD_W;

  // Output tdata layout: lane_bits, row_address
  localparam int unsigned OUT_TDATA_W  = 8;
  localparam int unsigned LANE_BITS_W  = 4;
  localparam int unsigned ROW_ADDR_W   = 4;
  // Output tuser layout: shift_pulse, latch_pulse, blank
  localparam int unsigned OUT_TUSER_W  = 3;
  localparam int unsigned OUT_SHIFT_BIT = 0;
  localparam int unsigned OUT_LATCH_BIT = 1;
  localparam int unsigned OUT_BLANK_BIT = 2;

  // What the scan sequencer decided for one tick
  typedef struct packed {
    logic                  latch;       // latch step (else shift step)
    logic                  frame_end;   // latch step of the last row
    logic [2:0]            bit_sel;     // bit position within the byte, 0 = MSB
    logic [ROW_ADDR_W-1:0] row_address; // row select lines
  } step_info_t;

endpackage

@@ rtl/lmrs_frame_store.sv @@
// ----------------------------------------------------------------------------
// lmrs_frame_store
// Four byte-wide plane memories sharing one write and one read address.
// One byte write and one four-lane read per cycle, read data registered.
// A clearing pass zeroes every entry after reset.
// ----------------------------------------------------------------------------
module lmrs_frame_store
  import lmrs_pkg::*;
#(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = 7
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     wr_en_i,
  input  logic [PLANE_W-1:0]       wr_plane_i,
  input  logic [AW-1:0]            wr_addr_i,
  input  logic [BYTE_W-1:0]        wr_data_i,
  input  logic                     rd_en_i,
  input  logic [AW-1:0]            rd_addr_i,
  output logic [LANES*BYTE_W-1:0]  rd_data_o,
  output logic                     clr_busy_o
);

  logic          clr_busy_q, clr_busy_d;
  logic [AW-1:0] clr_cnt_q, clr_cnt_d;

  // Sweep every address once after reset
  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_cnt_d  = clr_cnt_q;
    if (clr_busy_q) begin
      clr_cnt_d = clr_cnt_q + AW'(1);
      if (clr_cnt_q == AW'(DEPTH - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_cnt_q  <= clr_cnt_d;
    end
  end

  // One memory per plane
  for (genvar p = 0; p < LANES; p++) begin : g_plane
    logic [BYTE_W-1:0] mem_q [DEPTH];
    logic [BYTE_W-1:0] rd_q;
    logic              we;
    logic [AW-1:0]     waddr;
    logic [BYTE_W-1:0] wdata;

    assign we    = clr_busy_q || (wr_en_i && (wr_plane_i == PLANE_W'(p)));
    assign waddr = clr_busy_q ? clr_cnt_q : wr_addr_i;
    assign wdata = clr_busy_q ? '0 : wr_data_i;

    // Write port
    always_ff @(posedge clk_i) begin
      if (we) begin
        mem_q[waddr] <= wdata;
      end
    end

    // Registered read port, holds while no read is issued
    always_ff @(posedge clk_i) begin
      if (rd_en_i) begin
        rd_q <= mem_q[rd_addr_i];
      end
    end

    assign rd_data_o[p*BYTE_W +: BYTE_W] = rd_q;
  end

  assign clr_busy_o = clr_busy_q;

endmodule

@@ rtl/lmrs_scan_seq.sv @@
// ----------------------------------------------------------------------------
// lmrs_scan_seq
// Row/bit-step counters of the panel scan. Presents the read address and
// step info for the current tick and advances when a tick is taken.
// ----------------------------------------------------------------------------
module lmrs_scan_seq
  import lmrs_pkg::*;
#(
  parameter int unsigned ROWS      = 16,
  parameter int unsigned ROW_BYTES = 8,
  parameter int unsigned AW        = 7
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          advance_i,
  output logic [AW-1:0] rd_addr_o,
  output step_info_t    info_o
);

  localparam int unsigned STEPS = ROW_BYTES * 8;
  localparam int unsigned RW    = $clog2(ROWS);
  localparam int unsigned SW    = $clog2(STEPS + 1);

  logic [RW-1:0] scan_row_q, scan_row_d;
  logic [RW-1:0] shown_row_q, shown_row_d;
  logic [SW-1:0] bit_step_q, bit_step_d;
  logic          latch_step;
  logic [31:0]   addr_full;
  logic [31:0]   shown_ext;
  logic [31:0]   scan_ext;

  assign latch_step = (bit_step_q == SW'(STEPS));

  // Byte address of the current row and column
  assign addr_full = 32'(scan_row_q) * ROW_BYTES + 32'(bit_step_q >> 3);
  assign rd_addr_o = addr_full[AW-1:0];

  assign shown_ext = 32'(shown_row_q);
  assign scan_ext  = 32'(scan_row_q);

  // Step info: the latch step shows the row being latched
  always_comb begin
    info_o.latch       = latch_step;
    info_o.frame_end   = latch_step && (scan_row_q == RW'(ROWS - 1));
    info_o.bit_sel     = bit_step_q[2:0];
    info_o.row_address = latch_step ? scan_ext[ROW_ADDR_W-1:0]
                                    : shown_ext[ROW_ADDR_W-1:0];
  end

  // Advance the counters on a taken tick
  always_comb begin
    scan_row_d  = scan_row_q;
    shown_row_d = shown_row_q;
    bit_step_d  = bit_step_q;
    if (advance_i) begin
      if (latch_step) begin
        shown_row_d = scan_row_q;
        scan_row_d  = (scan_row_q == RW'(ROWS - 1)) ? '0 : scan_row_q + RW'(1);
        bit_step_d  = '0;
      end else begin
        bit_step_d  = bit_step_q + SW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_row_q  <= '0;
      shown_row_q <= '0;
      bit_step_q  <= '0;
    end else begin
      scan_row_q  <= scan_row_d;
      shown_row_q <= shown_row_d;
      bit_step_q  <= bit_step_d;
    end
  end

endmodule

@@ rtl/lmrs_out_reg.sv @@
// ----------------------------------------------------------------------------
// lmrs_out_reg
// Picks the lane bits out of the four read bytes and holds the finished
// pin step in the output register until the receiver takes it.
// ----------------------------------------------------------------------------
module lmrs_out_reg
  import lmrs_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    load_i,
  input  step_info_t              info_i,
  input  logic [LANES*BYTE_W-1:0] rd_data_i,
  output logic                    free_o,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [OUT_TDATA_W-1:0]  m_axis_tdata,
  output logic [OUT_TUSER_W-1:0]  m_axis_tuser,
  output logic                    m_axis_tlast
);

  logic                   valid_q, valid_d;
  logic [OUT_TDATA_W-1:0] tdata_q, tdata_d;
  logic [OUT_TUSER_W-1:0] tuser_q, tuser_d;
  logic                   tlast_q, tlast_d;
  logic [LANES-1:0]       lanes;
  logic [2:0]             bit_idx;

  // MSB goes first: bit step 0 takes bit 7
  assign bit_idx = ~info_i.bit_sel;

  always_comb begin
    for (int p = 0; p < LANES; p++) begin
      lanes[p] = rd_data_i[p*BYTE_W + 32'(bit_idx)] && !info_i.latch;
    end
  end

  assign free_o = !valid_q || m_axis_tready;

  // Load a new word or drop the taken one
  always_comb begin
    valid_d = valid_q;
    tdata_d = tdata_q;
    tuser_d = tuser_q;
    tlast_d = tlast_q;
    if (load_i) begin
      valid_d = 1'b1;
      tdata_d = {info_i.row_address, lanes};
      tuser_d[OUT_SHIFT_BIT] = !info_i.latch;
      tuser_d[OUT_LATCH_BIT] = info_i.latch;
      tuser_d[OUT_BLANK_BIT] = info_i.latch;
      tlast_d = info_i.frame_end;
    end else if (m_axis_tready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tdata_q <= tdata_d;
    tuser_q <= tuser_d;
    tlast_q <= tlast_d;
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = tdata_q;
  assign m_axis_tuser  = tuser_q;
  assign m_axis_tlast  = tlast_q;

endmodule

@@ rtl/led_matrix_row_scanner_top.sv @@
// ----------------------------------------------------------------------------
// led_matrix_row_scanner_top
// Scan controller for a multiplexed LED panel with four red lanes.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: tuser is the word kind. A write word stores pixel_byte at
//   (plane, row, column_byte) in the frame store; out-of-range writes are
//   dropped. A tick word produces one pin step on the master stream.
//   Each row takes ROW_BYTES*8 shift steps (lanes carry bits MSB first)
//   followed by one latch step with blank and latch pulse set; tlast marks
//   the latch step of the last row.
//   Path: a tick accepted on the slave side goes through the input register,
//   the frame store read and the output register to the master side.
//   Throughput: one word per cycle while the master side does not stall;
//   each word is either one store write or one four-lane store read.
//   Reset: counters go to row 0, step 0; then a clearing pass over all
//   ROWS*ROW_BYTES entries zeroes the frame store, tready stays low meanwhile.
//   Stall: when the master side stalls, the output register holds its word,
//   the pipe fills and tready drops; writes already taken still complete.
// ----------------------------------------------------------------------------
module led_matrix_row_scanner_top
  import lmrs_pkg::*;
#(
  parameter int unsigned ROWS      = 16,
  parameter int unsigned ROW_BYTES = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // plane, row, column_byte, pixel_byte
  input  logic                   s_axis_tuser,  // kind
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // lane_bits, row_address
  output logic [OUT_TUSER_W-1:0] m_axis_tuser,  // shift_pulse, latch_pulse, blank
  output logic                   m_axis_tlast   // frame_end
);

  localparam int unsigned DEPTH = ROWS * ROW_BYTES;
  localparam int unsigned AW    = $clog2(DEPTH);

  // Input register
  logic                 s1_valid_q, s1_valid_d;
  logic                 s1_kind_q;
  logic [PLANE_W-1:0]   s1_plane_q;
  logic [ROW_FLD_W-1:0] s1_row_q;
  logic [COL_FLD_W-1:0] s1_col_q;
  logic [BYTE_W-1:0]    s1_pix_q;

  // Read stage
  logic       s2_valid_q, s2_valid_d;
  step_info_t s2_info_q;

  logic                    in_fire;
  logic                    out_free;
  logic                    s2_adv, s2_free;
  logic                    tick_fire, s1_done, s1_free;
  logic                    wr_en, wr_in_range;
  logic [31:0]             wr_addr_full;
  logic [AW-1:0]           wr_addr;
  logic [AW-1:0]           rd_addr;
  step_info_t              step_info;
  logic [LANES*BYTE_W-1:0] rd_data;
  logic                    clr_busy;

  // Pipeline flow control
  assign s2_adv    = s2_valid_q && out_free;
  assign s2_free   = !s2_valid_q || out_free;
  assign tick_fire = s1_valid_q && (s1_kind_q == KIND_TICK) && s2_free;
  assign s1_done   = s1_valid_q && ((s1_kind_q == KIND_WRITE) || s2_free);
  assign s1_free   = !s1_valid_q || s1_done;

  assign s_axis_tready = !clr_busy && s1_free;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Frame byte write, dropped when out of range
  assign wr_in_range  = (32'(s1_row_q) < ROWS) && (32'(s1_col_q) < ROW_BYTES);
  assign wr_en        = s1_valid_q && (s1_kind_q == KIND_WRITE) && wr_in_range;
  assign wr_addr_full = 32'(s1_row_q) * ROW_BYTES + 32'(s1_col_q);
  assign wr_addr      = wr_addr_full[AW-1:0];

  // Input register control
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_done) begin
      s1_valid_d = 1'b0;
    end
  end

  // Read stage control
  always_comb begin
    s2_valid_d = s2_valid_q;
    if (tick_fire) begin
      s2_valid_d = 1'b1;
    end else if (s2_adv) begin
      s2_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  // Capture the accepted word
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_kind_q  <= s_axis_tuser;
      s1_plane_q <= s_axis_tdata[IN_PLANE_LSB +: PLANE_W];
      s1_row_q   <= s_axis_tdata[IN_ROW_LSB +: ROW_FLD_W];
      s1_col_q   <= s_axis_tdata[IN_COL_LSB +: COL_FLD_W];
      s1_pix_q   <= s_axis_tdata[IN_PIX_LSB +: BYTE_W];
    end
  end

  // Hold step info alongside the store read
  always_ff @(posedge clk_i) begin
    if (tick_fire) begin
      s2_info_q <= step_info;
    end
  end

  lmrs_scan_seq #(
    .ROWS      (ROWS),
    .ROW_BYTES (ROW_BYTES),
    .AW        (AW)
  ) u_scan_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (tick_fire),
    .rd_addr_o (rd_addr),
    .info_o    (step_info)
  );

  lmrs_frame_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_frame_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (wr_en),
    .wr_plane_i (s1_plane_q),
    .wr_addr_i  (wr_addr),
    .wr_data_i  (s1_pix_q),
    .rd_en_i    (tick_fire),
    .rd_addr_i  (rd_addr),
    .rd_data_o  (rd_data),
    .clr_busy_o (clr_busy)
  );

  lmrs_out_reg u_out_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (s2_adv),
    .info_i        (s2_info_q),
    .rd_data_i     (rd_data),
    .free_o        (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

@@ rtl/lmrs_checker.sv @@
// ----------------------------------------------------------------------------
// lmrs_checker
// Port-level checks on the pin step stream of the row scanner.
// ----------------------------------------------------------------------------
module lmrs_checker
  import lmrs_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [OUT_TUSER_W-1:0] m_axis_tuser,
  input logic                   m_axis_tlast
);

  // Hold a stalled word
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("stalled output word changed");

  // Every step is either a shift or a latch
  a_one_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser[OUT_SHIFT_BIT] != m_axis_tuser[OUT_LATCH_BIT])
    else $error("shift and latch pulse not exclusive");

  // Latch step blanks the panel and drives no lane data; shifts unblank
  a_latch_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (m_axis_tuser[OUT_BLANK_BIT] == m_axis_tuser[OUT_LATCH_BIT])
      && (!m_axis_tuser[OUT_LATCH_BIT] || m_axis_tdata[LANE_BITS_W-1:0] == '0))
    else $error("latch step not blanked or lanes not zero");

  // Frame end only on a latch step
  a_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[OUT_LATCH_BIT])
    else $error("frame end outside a latch step");

endmodule

bind led_matrix_row_scanner_top lmrs_checker u_lmrs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
